[src/cigsp_pkg.sv]
// ----------------------------------------------------------------------------
// cigsp_pkg: shared types and constants for the cigar string parser
// Transaction structs, op codes, command codes and byte decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package cigsp_pkg;

  // field widths of the transactions
  localparam int COUNT_W = 28;
  localparam int SUM_W   = 40;
  localparam int OP_W    = 4;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_D  = 4'd0;
  localparam logic [OP_W-1:0] OP_I  = 4'd1;
  localparam logic [OP_W-1:0] OP_H  = 4'd2;
  localparam logic [OP_W-1:0] OP_M  = 4'd3;
  localparam logic [OP_W-1:0] OP_N  = 4'd4;
  localparam logic [OP_W-1:0] OP_P  = 4'd5;
  localparam logic [OP_W-1:0] OP_S  = 4'd6;
  localparam logic [OP_W-1:0] OP_EQ = 4'd7;
  localparam logic [OP_W-1:0] OP_X  = 4'd8;

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h4d;
  localparam logic [7:0] CH_N     = 8'h4e;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_X     = 8'h58;

  // input transaction
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } char_t;

  // output transaction
  typedef struct packed {
    logic [OP_W-1:0]          op_code;
    logic [COUNT_W-1:0]       run_count;
    logic                     count_saturated;
    logic signed [SUM_W-1:0]  extra_length;
    logic                     bad_op;
    logic [7:0]               offending_byte;
  } token_t;

  // command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_TOKEN,
    CMD_ERROR,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic               clamped;
    logic [7:0]         text_byte;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic            hit;
    logic [OP_W-1:0] code;
  } op_decode_t;

  // case-folded match of an op letter
  function automatic op_decode_t op_of(input logic [7:0] b);
    logic [7:0] u;
    op_decode_t r;
    u = b;
    if (b >= CH_LOW_A && b <= CH_LOW_Z) u = b - CH_CASE;
    r.hit  = 1'b1;
    r.code = OP_D;
    unique case (u)
      CH_D:    r.code = OP_D;
      CH_I:    r.code = OP_I;
      CH_H:    r.code = OP_H;
      CH_M:    r.code = OP_M;
      CH_N:    r.code = OP_N;
      CH_P:    r.code = OP_P;
      CH_S:    r.code = OP_S;
      CH_EQ:   r.code = OP_EQ;
      CH_X:    r.code = OP_X;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/cigsp_fifo.sv]
// ----------------------------------------------------------------------------
// cigsp_fifo: small command queue
// Register based first-word-fall-through queue, push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cigsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // queue discipline
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[src/cigsp_front.sv]
// ----------------------------------------------------------------------------
// cigsp_front: byte classifier and run-length counter
// Accumulates decimal digits, decodes op letters and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cigsp_front import cigsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  char_valid,
  output logic       char_stall,
  input  wire char_t char_data,
  input  wire logic  queue_full,
  output logic       cmd_push,
  output cmd_t       cmd
);

  localparam int WIDE_W = COUNT_W + 4;

  logic [COUNT_W-1:0] acc;
  logic [COUNT_W-1:0] acc_next;
  logic               clamped;
  logic               clamped_next;
  logic               halted;
  logic               accept;
  logic               is_digit;
  logic [WIDE_W-1:0]  wide;
  logic [3:0]         digit;
  op_decode_t         dec;

  assign char_stall = queue_full;
  assign accept     = char_valid && !char_stall;
  assign is_digit   = (char_data.text_byte >= CH_0) && (char_data.text_byte <= CH_9);
  assign dec        = op_of(char_data.text_byte);
  assign digit      = 4'(char_data.text_byte - CH_0);

  // times ten plus digit, clamped at the count range
  always_comb begin
    wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + WIDE_W'(digit);
    if (wide[WIDE_W-1:COUNT_W] != '0) begin
      acc_next     = '1;
      clamped_next = 1'b1;
    end else begin
      acc_next     = wide[COUNT_W-1:0];
      clamped_next = clamped;
    end
  end

  // command to the back end
  always_comb begin
    cmd.op        = dec.code;
    cmd.count     = acc;
    cmd.clamped   = clamped;
    cmd.text_byte = char_data.text_byte;
    cmd.last      = char_data.last_byte;
    if (halted || is_digit) cmd.kind = CMD_CLEAR;
    else if (dec.hit)       cmd.kind = CMD_TOKEN;
    else                    cmd.kind = CMD_ERROR;
    cmd_push = accept && (char_data.last_byte || (!halted && !is_digit));
  end

  // counter and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      clamped <= 1'b0;
      halted  <= 1'b0;
    end else if (accept) begin
      if (char_data.last_byte) begin
        acc     <= '0;
        clamped <= 1'b0;
        halted  <= 1'b0;
      end else if (!halted) begin
        if (is_digit) begin
          acc     <= acc_next;
          clamped <= clamped_next;
        end else if (dec.hit) begin
          acc     <= '0;
          clamped <= 1'b0;
        end else begin
          halted  <= 1'b1;
        end
      end
    end
  end

  a_clamp_full: assert property (@(posedge clk) disable iff (rst) clamped |-> (acc == '1))
    else $error("clamped count not at its maximum");
  a_push_gated: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (char_valid && !queue_full))
    else $error("command issued without an accepted transaction");
  a_halt_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && char_data.last_byte) |=> (!halted && acc == '0))
    else $error("state not cleared after last byte");

endmodule

`default_nettype wire

[src/cigsp_back.sv]
// ----------------------------------------------------------------------------
// cigsp_back: extra length update and result register
// Applies saturating length updates and holds the outgoing transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cigsp_back import cigsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic queue_empty,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      tok_valid,
  input  wire logic tok_stall,
  output token_t    tok_data
);

  localparam int EXT_W = ((SUM_W > COUNT_W) ? SUM_W : COUNT_W + 1) + 1;
  localparam logic signed [EXT_W-1:0] SUM_MAX_E =
    {{(EXT_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SUM_MIN_E =
    {{(EXT_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [EXT_W-1:0] sum_e;
  logic signed [EXT_W-1:0] cnt_e;
  logic signed [EXT_W-1:0] res_e;
  logic                    out_free;

  assign out_free = !tok_valid || !tok_stall;
  assign cmd_pop  = !queue_empty && (out_free || cmd.kind == CMD_CLEAR);

  // saturating update of the running extra length
  always_comb begin
    sum_e = {{(EXT_W - SUM_W){sum[SUM_W-1]}}, sum};
    cnt_e = {{(EXT_W - COUNT_W){1'b0}}, cmd.count};
    res_e = sum_e;
    if (cmd.op == OP_D || cmd.op == OP_N)      res_e = sum_e + cnt_e;
    else if (cmd.op == OP_I || cmd.op == OP_S) res_e = sum_e - cnt_e;
    if (res_e > SUM_MAX_E)      sum_next = SUM_MAX_E[SUM_W-1:0];
    else if (res_e < SUM_MIN_E) sum_next = SUM_MIN_E[SUM_W-1:0];
    else                        sum_next = res_e[SUM_W-1:0];
  end

  // running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (cmd_pop) begin
      if (cmd.last)                 sum <= '0;
      else if (cmd.kind == CMD_TOKEN) sum <= sum_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (out_free) begin
      tok_valid <= cmd_pop && (cmd.kind != CMD_CLEAR);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd_pop && out_free) begin
      if (cmd.kind == CMD_ERROR) begin
        tok_data.op_code         <= OP_D;
        tok_data.run_count       <= '0;
        tok_data.count_saturated <= 1'b0;
        tok_data.extra_length    <= sum;
        tok_data.bad_op          <= 1'b1;
        tok_data.offending_byte  <= cmd.text_byte;
      end else begin
        tok_data.op_code         <= cmd.op;
        tok_data.run_count       <= cmd.count;
        tok_data.count_saturated <= cmd.clamped;
        tok_data.extra_length    <= sum_next;
        tok_data.bad_op          <= 1'b0;
        tok_data.offending_byte  <= 8'd0;
      end
    end
  end

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_data.bad_op) |-> (tok_data.op_code == OP_D &&
      tok_data.run_count == '0 && !tok_data.count_saturated))
    else $error("error transaction carries token fields");
  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind == CMD_CLEAR) |-> cmd.last)
    else $error("clear command without last byte");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind != CMD_CLEAR) |-> out_free)
    else $error("result popped while output register busy");

endmodule

`default_nettype wire

[src/cigar_string_parser.sv]
// Path: the command for an accepted byte is written into the command queue,
//   and the back end registers its result transaction in the output
//   register, from which it is offered.
// Throughput: one byte per cycle; the front stalls only when the queue is
//   full, which for QUEUE_DEPTH >= 2 happens only while the output stalls.
// Reset: synchronous rst clears the counter, running sum, queue and result valid flag.
// ----------------------------------------------------------------------------
// cigar_string_parser: streaming CIGAR text decoder
// Front end counts digits and decodes ops, back end tracks extra length.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_string_parser import cigsp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  char_valid,
  output logic       char_stall,
  input  wire char_t char_data,
  output logic       tok_valid,
  input  wire logic  tok_stall,
  output token_t     tok_data
);

  logic cmd_push;
  logic cmd_pop;
  logic queue_full;
  logic queue_empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  // byte classification
  cigsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // command queue
  cigsp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // length update and output
  cigsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .tok_data    (tok_data)
  );

endmodule

`default_nettype wire
